// ----- sv/slfp_pkg.sv -----
// shared types, codes and constants of the sync length field parser
package slfp_pkg;

	// fixed field widths
	localparam int BYTE_W    = 8;
	localparam int SYNC_W    = 32;
	localparam int TIMEOUT_W = 24;
	localparam int KIND_W    = 2;
	localparam int EVENT_W   = 3;
	localparam int POS_W     = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// default for the tick counter width
	localparam int TIMER_WIDTH_DEF = 24;

	// configuration reset values
	localparam logic [SYNC_W-1:0]    SYNC_PATTERN_RST  = 32'h1234_5678;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 24'd1000;

	// last position of the four-byte sync word
	localparam logic [POS_W-1:0] SYNC_POS_LAST = 2'd3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_PATTERN  = 2'd0,
		REG_TIMEOUT_TICKS = 2'd1
	} reg_idx_t;

	// input operation codes
	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// parser phases
	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_LEN1   = 3'd1,
		PH_LEN2   = 3'd2,
		PH_FIRST  = 3'd3,
		PH_SECOND = 3'd4
	} phase_t;

	// payload byte tags
	typedef enum logic [KIND_W-1:0] {
		KIND_NONE   = 2'd0,
		KIND_FIRST  = 2'd1,
		KIND_SECOND = 2'd2
	} kind_t;

	// event codes
	typedef enum logic [EVENT_W-1:0] {
		EV_NONE     = 3'd0,
		EV_SYNC     = 3'd1,
		EV_DONE     = 3'd2,
		EV_MISMATCH = 3'd3,
		EV_TIMEOUT  = 3'd4
	} event_t;

	// configuration register contents
	typedef struct packed {
		logic [SYNC_W-1:0]    sync_pattern;
		logic [TIMEOUT_W-1:0] timeout_ticks;
	} cfg_t;

	// one result transaction
	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] payload;
		logic              last;
		event_t            ev;
	} result_t;

endpackage

// ----- sv/slfp_core.sv -----
// parser state registers and the per-transaction update logic
module slfp_core #(
	parameter int TIMER_WIDTH = slfp_pkg::TIMER_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        operation,
	input  logic [slfp_pkg::BYTE_W-1:0] data_byte,
	input  slfp_pkg::cfg_t              cfg,
	output slfp_pkg::result_t           result
);

	localparam int CMP_W = (TIMER_WIDTH + 1 > slfp_pkg::TIMEOUT_W) ?
		TIMER_WIDTH + 1 : slfp_pkg::TIMEOUT_W;

	slfp_pkg::phase_t             phase_q, phase_d;
	logic [slfp_pkg::POS_W-1:0]   pos_q, pos_d;
	logic [slfp_pkg::BYTE_W-1:0]  first_rem_q, first_rem_d;
	logic [slfp_pkg::BYTE_W-1:0]  second_rem_q, second_rem_d;
	logic [TIMER_WIDTH-1:0]       elapsed_q, elapsed_d;

	logic                         is_tick;
	logic                         idle_tick;
	logic [CMP_W-1:0]             tick_next;
	logic                         timeout_hit;
	logic [TIMER_WIDTH-1:0]       elapsed_inc;
	logic [slfp_pkg::BYTE_W-1:0]  want_byte;
	logic                         sync_match;
	logic                         first_last;
	logic                         second_last;

	// tick counting and timeout compare
	assign is_tick     = (slfp_pkg::op_t'(operation) == slfp_pkg::OP_TICK);
	assign idle_tick   = (phase_q == slfp_pkg::PH_HUNT) && (pos_q == '0);
	assign tick_next   = CMP_W'(elapsed_q) + CMP_W'(1);
	assign timeout_hit = tick_next >= CMP_W'(cfg.timeout_ticks);
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + TIMER_WIDTH'(1);

	// expected sync byte, first byte in the top bits
	always_comb begin
		case (pos_q)
			2'd0:    want_byte = cfg.sync_pattern[31:24];
			2'd1:    want_byte = cfg.sync_pattern[23:16];
			2'd2:    want_byte = cfg.sync_pattern[15:8];
			default: want_byte = cfg.sync_pattern[7:0];
		endcase
	end

	assign sync_match  = (data_byte == want_byte);
	assign first_last  = (first_rem_q <= slfp_pkg::BYTE_W'(1));
	assign second_last = (second_rem_q <= slfp_pkg::BYTE_W'(1));

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (is_tick) begin
				if (!idle_tick && timeout_hit) begin
					phase_d = slfp_pkg::PH_HUNT;
				end
			end else begin
				unique case (phase_q)
					slfp_pkg::PH_HUNT: begin
						if (!sync_match) begin
							phase_d = slfp_pkg::PH_HUNT;
						end else if (pos_q == slfp_pkg::SYNC_POS_LAST) begin
							phase_d = slfp_pkg::PH_LEN1;
						end
					end
					slfp_pkg::PH_LEN1: phase_d = slfp_pkg::PH_LEN2;
					slfp_pkg::PH_LEN2: begin
						if (first_rem_q != '0) begin
							phase_d = slfp_pkg::PH_FIRST;
						end else if (data_byte != '0) begin
							phase_d = slfp_pkg::PH_SECOND;
						end else begin
							phase_d = slfp_pkg::PH_HUNT;
						end
					end
					slfp_pkg::PH_FIRST: begin
						if (first_last) begin
							phase_d = (second_rem_q != '0) ?
								slfp_pkg::PH_SECOND : slfp_pkg::PH_HUNT;
						end
					end
					slfp_pkg::PH_SECOND: begin
						if (second_last) begin
							phase_d = slfp_pkg::PH_HUNT;
						end
					end
					default: phase_d = slfp_pkg::PH_HUNT;
				endcase
			end
		end
	end

	// result and datapath counters
	always_comb begin
		pos_d        = pos_q;
		first_rem_d  = first_rem_q;
		second_rem_d = second_rem_q;
		elapsed_d    = elapsed_q;
		result.kind    = slfp_pkg::KIND_NONE;
		result.payload = '0;
		result.last    = 1'b0;
		result.ev      = slfp_pkg::EV_NONE;
		if (is_tick) begin
			if (!idle_tick) begin
				if (timeout_hit) begin
					pos_d     = '0;
					elapsed_d = '0;
					result.ev = slfp_pkg::EV_TIMEOUT;
				end else begin
					elapsed_d = elapsed_inc;
				end
			end
		end else begin
			unique case (phase_q)
				slfp_pkg::PH_LEN1: first_rem_d = data_byte;
				slfp_pkg::PH_LEN2: begin
					second_rem_d = data_byte;
					if (first_rem_q == '0 && data_byte == '0) begin
						pos_d     = '0;
						elapsed_d = '0;
						result.ev = slfp_pkg::EV_DONE;
					end
				end
				slfp_pkg::PH_FIRST: begin
					result.kind    = slfp_pkg::KIND_FIRST;
					result.payload = data_byte;
					result.last    = first_last;
					first_rem_d    = first_last ? '0 : first_rem_q - slfp_pkg::BYTE_W'(1);
					if (first_last && second_rem_q == '0) begin
						pos_d     = '0;
						elapsed_d = '0;
						result.ev = slfp_pkg::EV_DONE;
					end
				end
				slfp_pkg::PH_SECOND: begin
					result.kind    = slfp_pkg::KIND_SECOND;
					result.payload = data_byte;
					result.last    = second_last;
					second_rem_d   = second_last ? '0 : second_rem_q - slfp_pkg::BYTE_W'(1);
					if (second_last) begin
						pos_d     = '0;
						elapsed_d = '0;
						result.ev = slfp_pkg::EV_DONE;
					end
				end
				default: begin
					// hunt for the sync word
					if (!sync_match) begin
						pos_d     = '0;
						elapsed_d = '0;
						result.ev = slfp_pkg::EV_MISMATCH;
					end else if (pos_q == slfp_pkg::SYNC_POS_LAST) begin
						pos_d     = '0;
						elapsed_d = '0;
						result.ev = slfp_pkg::EV_SYNC;
					end else begin
						pos_d = pos_q + slfp_pkg::POS_W'(1);
					end
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= slfp_pkg::PH_HUNT;
			pos_q        <= '0;
			first_rem_q  <= '0;
			second_rem_q <= '0;
			elapsed_q    <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			first_rem_q  <= first_rem_d;
			second_rem_q <= second_rem_d;
			elapsed_q    <= elapsed_d;
		end
	end

endmodule

// ----- sv/slfp_out_buf.sv -----
// result register with a skid entry that absorbs one result while the output stalls
module slfp_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  slfp_pkg::result_t push_data,
	output logic              push_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output slfp_pkg::result_t out_data
);

	logic              main_valid_q;
	slfp_pkg::result_t main_q;
	logic              skid_valid_q;
	slfp_pkg::result_t skid_q;
	logic              pop;

	assign pop        = main_valid_q && out_ready;
	assign push_ready = !skid_valid_q;
	assign out_valid  = main_valid_q;
	assign out_data   = main_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

// ----- sv/sync_length_field_parser.sv -----
// top level of the sync word, length prefixed two-field frame parser
//
//  channel  signals                                        direction
//  cfg      cfg_valid cfg_ready cfg_index cfg_data         in  (write)
//  in       in_valid in_ready operation data_byte          in
//  out      out_valid out_ready byte_kind payload_byte     out
//           field_last event_res
//
// one input transaction is taken per cycle while in_ready is high, and its result is
// registered in the result register or the skid entry. the two entries absorb an output
// stall; in_ready drops only while both entries hold unread results.
// arst_n clears the parser to the sync hunt and loads the default sync word and
// timeout; cfg_ready is always high.
module sync_length_field_parser #(
	parameter int TIMER_WIDTH = slfp_pkg::TIMER_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [slfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             operation,
	input  logic [slfp_pkg::BYTE_W-1:0]      data_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [slfp_pkg::KIND_W-1:0]      byte_kind,
	output logic [slfp_pkg::BYTE_W-1:0]      payload_byte,
	output logic                             field_last,
	output logic [slfp_pkg::EVENT_W-1:0]     event_res
);

	slfp_pkg::cfg_t    cfg_q;
	slfp_pkg::result_t step_res;
	slfp_pkg::result_t out_res;
	logic              in_accept;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_pattern  <= slfp_pkg::SYNC_PATTERN_RST;
			cfg_q.timeout_ticks <= slfp_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				slfp_pkg::REG_SYNC_PATTERN:
					cfg_q.sync_pattern <= cfg_data[slfp_pkg::SYNC_W-1:0];
				slfp_pkg::REG_TIMEOUT_TICKS:
					cfg_q.timeout_ticks <= cfg_data[slfp_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// parser
	slfp_core #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.operation (operation),
		.data_byte (data_byte),
		.cfg       (cfg_q),
		.result    (step_res)
	);

	// result stage
	slfp_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_accept),
		.push_data  (step_res),
		.push_ready (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_res)
	);

	assign byte_kind    = out_res.kind;
	assign payload_byte = out_res.payload;
	assign field_last   = out_res.last;
	assign event_res    = out_res.ev;

endmodule
